### rtl/vspc_pkg.sv
// Shared types and constants for the virtual subnet packet classifier.
// Holds the channel payload structs, command and action codes and the
// protocol constants; depends on nothing.
`default_nettype none

package vspc_pkg;

  // Command codes of an input transaction
  localparam logic [1:0] CMD_ROUTE  = 2'd0;
  localparam logic [1:0] CMD_ADD    = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;
  localparam logic [1:0] CMD_CLEAR  = 2'd3;

  // Forwarding actions of a result
  localparam logic [1:0] ACT_DROP   = 2'd0;
  localparam logic [1:0] ACT_CLIENT = 2'd1;
  localparam logic [1:0] ACT_TUNNEL = 2'd2;
  localparam logic [1:0] ACT_BCAST  = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_SUBNET_BASE = 2'd0;
  localparam logic [1:0] CFG_SUBNET_MASK = 2'd1;
  localparam logic [1:0] CFG_EXTRA_BCAST = 2'd2;

  // Protocol constants
  localparam logic [31:0] ALL_ONES          = 32'hFFFF_FFFF;
  localparam logic [31:0] EXTRA_BCAST_RESET = 32'h0A08_00FF;
  localparam logic [15:0] MIN_PACKET        = 16'd20;
  localparam logic [3:0]  IPV4_VERSION      = 4'd4;

  // Depth of the queues between the parts of the block
  localparam int QUEUE_DEPTH = 2;

  localparam int NUM_COUNTERS = 5;
  localparam int CNT_ROUTED   = 0;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [3:0]  ip_version;
    logic [3:0]  header_words;
    logic [15:0] packet_length;
    logic [31:0] dest_addr;
    logic [31:0] client_addr;
    logic [15:0] client_tag;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] dest_client;
    logic        status;
    logic [31:0] count_routed;
    logic [31:0] count_dropped;
    logic [31:0] count_to_client;
    logic [31:0] count_to_tunnel;
    logic [31:0] count_broadcast;
  } out_item_t;

  // Decoded command passed from the front end to the table engine
  typedef struct packed {
    logic [1:0]  cmd;
    logic        drop;   // route fails header or subnet checks
    logic        bcast;  // destination is subnet broadcast or all ones
    logic [31:0] key;    // lookup address: destination or client address
    logic [15:0] tag;
  } op_t;

endpackage

`default_nettype wire

### rtl/vspc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Used for the host table; depends on nothing.
`default_nettype none

module vspc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire  [$clog2(DEPTH)-1:0] waddr,
  input  wire  [WIDTH-1:0]         wdata,
  input  wire  [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write one entry, read one entry every cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

### rtl/vspc_fifo.sv
// Small flip-flop queue with push/full and pop/empty sides.
// Generic in width and depth; depends on nothing.
`default_nettype none

module vspc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              push,
  input  wire  [WIDTH-1:0] wdata,
  output logic             full,
  input  wire              pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  // Advance pointers with wrap at the queue depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the pushed transaction
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

### rtl/vspc_front.sv
// Front end: configuration registers and header / subnet classification.
// Turns an input transaction into a decoded command; uses vspc_pkg.
`default_nettype none

module vspc_front (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      cfg_we,
  input  wire  [1:0]               cfg_idx,
  input  wire  [31:0]              cfg_wdata,
  input  wire  vspc_pkg::in_item_t in_item,
  output vspc_pkg::op_t            op
);

  logic [31:0] subnet_base_r;
  logic [31:0] subnet_mask_r;
  logic [31:0] extra_bcast_r;

  logic [5:0]  hdr_bytes;
  logic        bad_hdr;
  logic [31:0] net_part;
  logic        in_subnet;
  logic        any_bcast;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      subnet_base_r <= '0;
      subnet_mask_r <= '0;
      extra_bcast_r <= vspc_pkg::EXTRA_BCAST_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        vspc_pkg::CFG_SUBNET_BASE: subnet_base_r <= cfg_wdata;
        vspc_pkg::CFG_SUBNET_MASK: subnet_mask_r <= cfg_wdata;
        vspc_pkg::CFG_EXTRA_BCAST: extra_bcast_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Check the IPv4 header fields
  assign hdr_bytes = {in_item.header_words, 2'b00};
  assign bad_hdr   = (in_item.packet_length < vspc_pkg::MIN_PACKET) ||
                     (in_item.ip_version != vspc_pkg::IPV4_VERSION) ||
                     (hdr_bytes < 6'(vspc_pkg::MIN_PACKET)) ||
                     (16'(hdr_bytes) > in_item.packet_length);

  // Check the destination against the virtual subnet
  assign net_part  = subnet_base_r & subnet_mask_r;
  assign in_subnet = ((in_item.dest_addr & subnet_mask_r) == net_part);
  assign any_bcast = (in_item.dest_addr == vspc_pkg::ALL_ONES) ||
                     (in_item.dest_addr == extra_bcast_r);

  // Build the decoded command
  always_comb begin
    op.cmd   = in_item.cmd;
    op.drop  = bad_hdr || (!in_subnet && !any_bcast);
    op.bcast = (in_item.dest_addr == (net_part | ~subnet_mask_r)) ||
               (in_item.dest_addr == vspc_pkg::ALL_ONES);
    op.key   = (in_item.cmd == vspc_pkg::CMD_ADD) ? in_item.client_addr
                                                  : in_item.dest_addr;
    op.tag   = in_item.client_tag;
  end

endmodule

`default_nettype wire

### rtl/vspc_back.sv
// Back end: host table engine and statistics counters.
// Scans the table RAM one entry a cycle; uses vspc_pkg and vspc_ram.
`default_nettype none

module vspc_back #(
  parameter int TABLE_DEPTH = 64,
  parameter int CLIENT_BITS = 16
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  q_empty,
  input  wire vspc_pkg::op_t   q_data,
  output logic                 q_pop,
  input  wire                  res_full,
  output logic                 res_push,
  output vspc_pkg::out_item_t  res_data,
  output logic                 init_busy
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int EW = 1 + 32 + CLIENT_BITS;
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_DEPTH - 1);

  localparam logic [1:0] ST_CLR  = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_RES  = 2'd3;

  logic [1:0]             state_r, state_nxt;
  vspc_pkg::op_t          op_r, op_nxt;
  logic [IW-1:0]          idx_r, idx_nxt;
  logic                   issue_done_r, issue_done_nxt;
  logic                   dat_vld_r, dat_vld_nxt;
  logic [IW-1:0]          dat_idx_r, dat_idx_nxt;
  logic                   free_found_r, free_found_nxt;
  logic [IW-1:0]          free_idx_r, free_idx_nxt;
  logic [1:0]             act_r, act_nxt;
  logic [15:0]            tgt_r, tgt_nxt;
  logic                   status_r, status_nxt;
  logic [31:0]            cnt_r   [vspc_pkg::NUM_COUNTERS];
  logic [31:0]            cnt_nxt [vspc_pkg::NUM_COUNTERS];

  logic                   ram_we;
  logic [IW-1:0]          ram_waddr;
  logic [EW-1:0]          ram_wdata;
  logic [EW-1:0]          ram_rdata;

  logic                   ent_valid;
  logic [31:0]            ent_addr;
  logic [CLIENT_BITS-1:0] ent_client;
  logic [CLIENT_BITS-1:0] tag_id;
  logic                   hit;
  logic                   last;

  vspc_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  // Unpack the entry read in the previous cycle
  assign ent_valid  = ram_rdata[EW-1];
  assign ent_addr   = ram_rdata[EW-2:CLIENT_BITS];
  assign ent_client = ram_rdata[CLIENT_BITS-1:0];
  assign tag_id     = CLIENT_BITS'(op_r.tag);
  assign hit        = ent_valid && (ent_addr == op_r.key);
  assign last       = (dat_idx_r == LAST_IDX);
  assign init_busy  = (state_r == ST_CLR);

  // Update counters for the finished command
  always_comb begin
    for (int k = 0; k < vspc_pkg::NUM_COUNTERS; k++) begin
      cnt_nxt[k] = cnt_r[k];
    end
    case (op_r.cmd)
      vspc_pkg::CMD_ROUTE: begin
        cnt_nxt[vspc_pkg::CNT_ROUTED] = cnt_r[vspc_pkg::CNT_ROUTED] + 32'd1;
        for (int k = 0; k < 4; k++) begin
          if (act_r == 2'(k)) begin
            cnt_nxt[k + 1] = cnt_r[k + 1] + 32'd1;
          end
        end
      end
      vspc_pkg::CMD_CLEAR: begin
        for (int k = 0; k < vspc_pkg::NUM_COUNTERS; k++) begin
          cnt_nxt[k] = '0;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    res_data.action          = act_r;
    res_data.dest_client     = tgt_r;
    res_data.status          = status_r;
    res_data.count_routed    = cnt_nxt[0];
    res_data.count_dropped   = cnt_nxt[1];
    res_data.count_to_client = cnt_nxt[2];
    res_data.count_to_tunnel = cnt_nxt[3];
    res_data.count_broadcast = cnt_nxt[4];
  end

  // Sequence clearing, scanning and result hand-off
  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    idx_nxt        = idx_r;
    issue_done_nxt = issue_done_r;
    dat_vld_nxt    = 1'b0;
    dat_idx_nxt    = dat_idx_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    act_nxt        = act_r;
    tgt_nxt        = tgt_r;
    status_nxt     = status_r;
    q_pop          = 1'b0;
    res_push       = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = dat_idx_r;
    ram_wdata      = ram_rdata;

    case (state_r)
      // Invalidate every table entry after reset
      ST_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r;
        ram_wdata = '0;
        if (idx_r == LAST_IDX) begin
          idx_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      // Take the next command from the queue
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop          = 1'b1;
          op_nxt         = q_data;
          idx_nxt        = '0;
          issue_done_nxt = 1'b0;
          free_found_nxt = 1'b0;
          tgt_nxt        = '0;
          status_nxt     = 1'b0;
          act_nxt        = vspc_pkg::ACT_DROP;
          if (q_data.cmd == vspc_pkg::CMD_ROUTE && !q_data.drop) begin
            act_nxt = q_data.bcast ? vspc_pkg::ACT_BCAST : vspc_pkg::ACT_TUNNEL;
          end
          if (q_data.cmd == vspc_pkg::CMD_CLEAR ||
              (q_data.cmd == vspc_pkg::CMD_ROUTE && q_data.drop)) begin
            state_nxt = ST_RES;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        // Issue the next table read
        if (!issue_done_r) begin
          dat_vld_nxt = 1'b1;
          dat_idx_nxt = idx_r;
          if (idx_r == LAST_IDX) begin
            issue_done_nxt = 1'b1;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
        // Evaluate the entry returned by the RAM
        if (dat_vld_r) begin
          case (op_r.cmd)
            vspc_pkg::CMD_ROUTE: begin
              if (hit) begin
                if (ent_client != '0) begin
                  act_nxt = vspc_pkg::ACT_CLIENT;
                  tgt_nxt = 16'(ent_client);
                end
                state_nxt = ST_RES;
              end else if (last) begin
                state_nxt = ST_RES;
              end
            end
            vspc_pkg::CMD_ADD: begin
              if (hit) begin
                ram_we    = 1'b1;
                ram_wdata = {1'b1, ent_addr, tag_id};
                state_nxt = ST_RES;
              end else begin
                if (!ent_valid && !free_found_r) begin
                  free_found_nxt = 1'b1;
                  free_idx_nxt   = dat_idx_r;
                end
                if (last) begin
                  state_nxt = ST_RES;
                  if (free_found_r) begin
                    ram_we    = 1'b1;
                    ram_waddr = free_idx_r;
                    ram_wdata = {1'b1, op_r.key, tag_id};
                  end else if (!ent_valid) begin
                    ram_we    = 1'b1;
                    ram_wdata = {1'b1, op_r.key, tag_id};
                  end else begin
                    status_nxt = 1'b1;
                  end
                end
              end
            end
            vspc_pkg::CMD_REMOVE: begin
              if (ent_valid && ent_client == tag_id) begin
                ram_we    = 1'b1;
                ram_wdata = {1'b0, ent_addr, ent_client};
              end
              if (last) begin
                state_nxt = ST_RES;
              end
            end
            default: state_nxt = ST_RES;
          endcase
        end
        // Drop reads still in flight when the scan ends
        if (state_nxt != ST_SCAN) begin
          dat_vld_nxt = 1'b0;
        end
      end

      // Hand the result to the output queue
      ST_RES: begin
        if (!res_full) begin
          res_push  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLR;
      idx_r     <= '0;
      dat_vld_r <= 1'b0;
      for (int k = 0; k < vspc_pkg::NUM_COUNTERS; k++) begin
        cnt_r[k] <= '0;
      end
    end else begin
      state_r   <= state_nxt;
      idx_r     <= idx_nxt;
      dat_vld_r <= dat_vld_nxt;
      if (res_push) begin
        for (int k = 0; k < vspc_pkg::NUM_COUNTERS; k++) begin
          cnt_r[k] <= cnt_nxt[k];
        end
      end
    end
  end

  // Hold the working command and scan bookkeeping
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    issue_done_r <= issue_done_nxt;
    dat_idx_r    <= dat_idx_nxt;
    free_found_r <= free_found_nxt;
    free_idx_r   <= free_idx_nxt;
    act_r        <= act_nxt;
    tgt_r        <= tgt_nxt;
    status_r     <= status_nxt;
  end

endmodule

`default_nettype wire

### rtl/virtual_subnet_packet_classifier_unit.sv
// Virtual subnet packet classifier: top level.
// Channels: an input queue port (in_push / in_full / in_data) takes one
//   transaction per command: route a packet header, add a host entry, remove
//   a client or clear the counters. A result queue port (out_empty / out_pop
//   / out_data) returns exactly one result per command, in order, with the
//   action, target client, add status and the five counters after the command.
//   cfg_we / cfg_idx / cfg_wdata write subnet base, mask and extra broadcast;
//   write them only while no command is outstanding.
// Flow: the front end classifies the header in the accept cycle; a route
//   that fails its checks and a counter clear go straight to the result in
//   the engine. A route or an add that reaches the table scans it one entry a
//   cycle and stops at the first entry with its address; remove always scans
//   the whole table. The engine works on one command at a time, so the table
//   scan sets the throughput.
// Reset: counters clear, the queues empty, and a clearing pass invalidates
//   every table entry, with in_full held high meanwhile.
// Stall: a two-entry queue sits between front end and engine and another at
//   the output; a stalled receiver fills them and then raises in_full.
`default_nettype none

module virtual_subnet_packet_classifier_unit #(
  parameter int TABLE_DEPTH = 64,
  parameter int CLIENT_BITS = 16
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_push,
  input  wire vspc_pkg::in_item_t  in_data,
  output logic                     in_full,
  input  wire                      out_pop,
  output vspc_pkg::out_item_t      out_data,
  output logic                     out_empty,
  input  wire                      cfg_we,
  input  wire  [1:0]               cfg_idx,
  input  wire  [31:0]              cfg_wdata
);

  vspc_pkg::op_t       front_op;
  vspc_pkg::op_t       q_data;
  logic                q_full;
  logic                q_empty;
  logic                q_pop;
  logic                init_busy;
  logic                res_full;
  logic                res_push;
  vspc_pkg::out_item_t res_data;

  // Refuse input while the table clears or the command queue is full
  assign in_full = q_full || init_busy;

  vspc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_item   (in_data),
    .op        (front_op)
  );

  vspc_fifo #(
    .WIDTH ($bits(vspc_pkg::op_t)),
    .DEPTH (vspc_pkg::QUEUE_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push && !in_full),
    .wdata (front_op),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_data),
    .empty (q_empty)
  );

  vspc_back #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .CLIENT_BITS (CLIENT_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_data  (res_data),
    .init_busy (init_busy)
  );

  vspc_fifo #(
    .WIDTH ($bits(vspc_pkg::out_item_t)),
    .DEPTH (vspc_pkg::QUEUE_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_data),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (out_data),
    .empty (out_empty)
  );

endmodule

`default_nettype wire

### rtl/vspc_checker.sv
// Port-level checks for the virtual subnet packet classifier.
// Bound to the top level; uses vspc_pkg.
`default_nettype none

module vspc_checker (
  input wire                       clk,
  input wire                       rst_n,
  input wire                       in_full,
  input wire                       out_empty,
  input wire                       out_pop,
  input wire vspc_pkg::out_item_t  out_data
);

  // Reset empties the result queue
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

  // Reset starts the table clearing pass, which blocks input
  a_reset_full: assert property (@(posedge clk) !rst_n |=> in_full)
    else $error("input accepted during table clearing");

  // Only a client action names a client
  a_target: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.action != vspc_pkg::ACT_CLIENT) |->
      (out_data.dest_client == 16'd0))
    else $error("target client set without client action");

  // A full table is reported only on a non-route result
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.status) |-> (out_data.action == vspc_pkg::ACT_DROP))
    else $error("table full status with forwarding action");

  // A waiting result holds until popped
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_data)))
    else $error("waiting result changed");

endmodule

bind virtual_subnet_packet_classifier_unit vspc_checker u_vspc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_full   (in_full),
  .out_empty (out_empty),
  .out_pop   (out_pop),
  .out_data  (out_data)
);

`default_nettype wire

### dv/virtual_subnet_packet_classifier_unit_tb.sv
// Self-checking testbench for the virtual subnet packet classifier.
// Drives commands through the input queue port, predicts every result with a
// behavioral host table and counter model; depends on rtl/vspc_pkg.sv and the top level.
`timescale 1ns / 100ps

module virtual_subnet_packet_classifier_unit_tb;

  localparam int TABLE_DEPTH = 64;
  localparam int CLIENT_BITS = 16;
  localparam int POOL_SIZE   = 96;
  localparam int PHASE_ITEMS = 228;
  localparam int VER4        = int'(vspc_pkg::IPV4_VERSION);
  localparam logic [15:0] ID_MASK = 16'((33'd1 << CLIENT_BITS) - 33'd1);

  logic                clk;
  logic                rst_n     = 1'b0;
  logic                in_push   = 1'b0;
  vspc_pkg::in_item_t  in_data   = '0;
  logic                in_full;
  logic                out_pop   = 1'b0;
  vspc_pkg::out_item_t out_data;
  logic                out_empty;
  logic                cfg_we    = 1'b0;
  logic [1:0]          cfg_idx   = '0;
  logic [31:0]         cfg_wdata = '0;

  virtual_subnet_packet_classifier_unit #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .CLIENT_BITS (CLIENT_BITS)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_data   (in_data),
    .in_full   (in_full),
    .out_pop   (out_pop),
    .out_data  (out_data),
    .out_empty (out_empty),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Predictor state: host table, packet counters, subnet registers
  logic [31:0] host_addr  [TABLE_DEPTH];
  logic [15:0] host_id    [TABLE_DEPTH];
  bit          host_valid [TABLE_DEPTH];
  logic [31:0] pkt_count  [vspc_pkg::NUM_COUNTERS] = '{default: '0};
  logic [31:0] net_base    = '0;
  logic [31:0] net_mask    = '0;
  logic [31:0] extra_bcast = vspc_pkg::EXTRA_BCAST_RESET;

  // Addresses that stimulus draws hosts and destinations from
  logic [31:0] host_pool [POOL_SIZE];

  vspc_pkg::in_item_t  cmd_queue[$];      // commands waiting to be offered
  vspc_pkg::out_item_t verdict_queue[$];  // predicted results, oldest first

  int n_errors   = 0;
  int n_accepted = 0;
  int tx_gap     = 0;
  int rx_gap     = 0;
  bit tx_eager   = 1'b0;
  bit rx_eager   = 1'b0;
  bit rx_hold    = 1'b0;
  bit push_taken = 1'b0;
  bit pop_taken  = 1'b0;

  // Append a command to the offer queue
  function automatic void enqueue(input vspc_pkg::in_item_t it);
    cmd_queue = {cmd_queue, it};
  endfunction

  // Apply one command to the model and return the result it must produce
  function automatic vspc_pkg::out_item_t apply_command(input vspc_pkg::in_item_t c);
    vspc_pkg::out_item_t r;
    logic [15:0]         tag;
    logic [5:0]          hdr_bytes;
    logic [31:0]         net_bcast;
    bit                  in_net;
    bit                  matched;
    int                  free_slot;
    int                  i;
    r = '0;
    tag = c.client_tag & ID_MASK;
    matched = 1'b0;
    case (c.cmd)
      vspc_pkg::CMD_ROUTE: begin
        hdr_bytes = {c.header_words, 2'b00};
        net_bcast = (net_base & net_mask) | ~net_mask;
        in_net = (c.dest_addr & net_mask) == (net_base & net_mask);
        r.action = vspc_pkg::ACT_TUNNEL;
        if (c.packet_length < vspc_pkg::MIN_PACKET ||
            c.ip_version != vspc_pkg::IPV4_VERSION ||
            16'(hdr_bytes) < vspc_pkg::MIN_PACKET || 16'(hdr_bytes) > c.packet_length) begin
          r.action = vspc_pkg::ACT_DROP;
        end else if (!in_net && c.dest_addr != vspc_pkg::ALL_ONES &&
                     c.dest_addr != extra_bcast) begin
          r.action = vspc_pkg::ACT_DROP;
        end else begin
          // first entry with this address decides; a zero id falls through
          for (i = 0; i < TABLE_DEPTH && !matched; i++) begin
            if (host_valid[i] && host_addr[i] == c.dest_addr) begin
              matched = 1'b1;
              if (host_id[i] != '0) begin
                r.action = vspc_pkg::ACT_CLIENT;
                r.dest_client = host_id[i];
              end
            end
          end
          if (r.action != vspc_pkg::ACT_CLIENT &&
              (c.dest_addr == net_bcast || c.dest_addr == vspc_pkg::ALL_ONES)) begin
            r.action = vspc_pkg::ACT_BCAST;
          end
        end
        pkt_count[vspc_pkg::CNT_ROUTED] = pkt_count[vspc_pkg::CNT_ROUTED] + 32'd1;
        pkt_count[1 + int'(r.action)] = pkt_count[1 + int'(r.action)] + 32'd1;
      end
      vspc_pkg::CMD_ADD: begin
        free_slot = -1;
        for (i = 0; i < TABLE_DEPTH && !matched; i++) begin
          if (host_valid[i] && host_addr[i] == c.client_addr) begin
            host_id[i] = tag;
            matched = 1'b1;
          end else if (!host_valid[i] && free_slot < 0) begin
            free_slot = i;
          end
        end
        if (!matched) begin
          if (free_slot < 0) begin
            r.status = 1'b1;
          end else begin
            host_addr[free_slot]  = c.client_addr;
            host_id[free_slot]    = tag;
            host_valid[free_slot] = 1'b1;
          end
        end
      end
      vspc_pkg::CMD_REMOVE: begin
        for (i = 0; i < TABLE_DEPTH; i++) begin
          if (host_valid[i] && host_id[i] == tag) host_valid[i] = 1'b0;
        end
      end
      default: begin
        for (i = 0; i < vspc_pkg::NUM_COUNTERS; i++) pkt_count[i] = '0;
      end
    endcase
    r.count_routed    = pkt_count[0];
    r.count_dropped   = pkt_count[1];
    r.count_to_client = pkt_count[2];
    r.count_to_tunnel = pkt_count[3];
    r.count_broadcast = pkt_count[4];
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0h, got %0h", name, want_v, got_v);
      n_errors++;
    end
  endtask

  // Sample both handshakes; check results first, then predict the new command
  always @(posedge clk) begin : sample
    vspc_pkg::out_item_t want;
    push_taken <= rst_n && in_push && !in_full;
    pop_taken  <= rst_n && out_pop && !out_empty;
    if (rst_n && out_pop && !out_empty) begin
      if (verdict_queue.size() == 0) begin
        $error("result transaction with no command outstanding");
        n_errors++;
      end else begin
        want = verdict_queue.pop_front();
        check_field("action", 32'(want.action), 32'(out_data.action));
        check_field("dest_client", 32'(want.dest_client), 32'(out_data.dest_client));
        check_field("status", 32'(want.status), 32'(out_data.status));
        check_field("count_routed", want.count_routed, out_data.count_routed);
        check_field("count_dropped", want.count_dropped, out_data.count_dropped);
        check_field("count_to_client", want.count_to_client, out_data.count_to_client);
        check_field("count_to_tunnel", want.count_to_tunnel, out_data.count_to_tunnel);
        check_field("count_broadcast", want.count_broadcast, out_data.count_broadcast);
      end
    end
    if (rst_n && in_push && !in_full) begin
      verdict_queue = {verdict_queue, apply_command(in_data)};
      n_accepted++;
    end
  end

  // Sender: drop push after a transaction, wait the drawn gap, offer the next
  always @(negedge clk) begin : drive_in
    logic               nxt_push;
    vspc_pkg::in_item_t nxt_data;
    nxt_push = in_push;
    nxt_data = in_data;
    if (rst_n) begin
      if (in_push && push_taken) nxt_push = 1'b0;
      if (!nxt_push) begin
        if (tx_gap > 0) begin
          tx_gap = tx_gap - 1;
        end else if (cmd_queue.size() > 0) begin
          nxt_data = cmd_queue.pop_front();
          nxt_push = 1'b1;
          tx_gap = tx_eager ? 0 : $urandom_range(0, 9);
        end
      end
    end
    in_push <= nxt_push;
    in_data <= nxt_data;
  end

  // Receiver: wait a drawn gap after each result, hold off on request
  always @(negedge clk) begin : drive_out
    logic nxt_pop;
    nxt_pop = out_pop;
    if (rst_n) begin
      if (out_pop && pop_taken) begin
        nxt_pop = 1'b0;
        rx_gap = rx_eager ? 0 : $urandom_range(0, 9);
      end
      if (rx_hold) begin
        nxt_pop = 1'b0;
      end else if (!nxt_pop) begin
        if (rx_gap > 0) rx_gap = rx_gap - 1;
        else nxt_pop = 1'b1;
      end
    end
    out_pop <= nxt_pop;
  end

  // Long receiver hold-off mid-run so the internal queues fill and in_full rises
  initial begin
    wait (n_accepted >= 600);
    @(posedge clk);
    rx_hold = 1'b1;
    repeat (300) @(posedge clk);
    rx_hold = 1'b0;
  end

  initial begin
    #(30_000_000);
    $display("virtual_subnet_packet_classifier_unit: mismatch");
    $finish;
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      vspc_pkg::CFG_SUBNET_BASE: net_base = val;
      vspc_pkg::CFG_SUBNET_MASK: net_mask = val;
      default:                   extra_bcast = val;
    endcase
  endtask

  // Program the subnet and refresh the host address pool inside it
  task automatic set_subnet(input logic [31:0] base, input logic [31:0] mask,
                            input logic [31:0] extra);
    write_reg(vspc_pkg::CFG_SUBNET_BASE, base);
    write_reg(vspc_pkg::CFG_SUBNET_MASK, mask);
    write_reg(vspc_pkg::CFG_EXTRA_BCAST, extra);
    foreach (host_pool[k]) host_pool[k] = (base & mask) | ($urandom & ~mask);
  endtask

  // Wait until every offered command is taken and every result has come back
  task automatic wait_idle();
    while (cmd_queue.size() != 0 || in_push || verdict_queue.size() != 0)
      @(posedge clk);
  endtask

  // Every field starts random so that unused fields toggle too
  function automatic vspc_pkg::in_item_t noise_item();
    vspc_pkg::in_item_t it;
    it.cmd           = 2'($urandom);
    it.ip_version    = 4'($urandom);
    it.header_words  = 4'($urandom);
    it.packet_length = 16'($urandom);
    it.dest_addr     = $urandom;
    it.client_addr   = $urandom;
    it.client_tag    = 16'($urandom);
    return it;
  endfunction

  function automatic vspc_pkg::in_item_t route_item(input int ver, input int ihl,
                                                    input int len,
                                                    input logic [31:0] dest);
    vspc_pkg::in_item_t it;
    it = noise_item();
    it.cmd           = vspc_pkg::CMD_ROUTE;
    it.ip_version    = 4'(ver);
    it.header_words  = 4'(ihl);
    it.packet_length = 16'(len);
    it.dest_addr     = dest;
    return it;
  endfunction

  function automatic vspc_pkg::in_item_t add_item(input logic [31:0] addr,
                                                  input logic [15:0] tag);
    vspc_pkg::in_item_t it;
    it = noise_item();
    it.cmd         = vspc_pkg::CMD_ADD;
    it.client_addr = addr;
    it.client_tag  = tag;
    return it;
  endfunction

  function automatic vspc_pkg::in_item_t remove_item(input logic [15:0] tag);
    vspc_pkg::in_item_t it;
    it = noise_item();
    it.cmd        = vspc_pkg::CMD_REMOVE;
    it.client_tag = tag;
    return it;
  endfunction

  function automatic vspc_pkg::in_item_t clear_item();
    vspc_pkg::in_item_t it;
    it = noise_item();
    it.cmd = vspc_pkg::CMD_CLEAR;
    return it;
  endfunction

  // Mostly a small set of client ids so adds and removes collide
  function automatic logic [15:0] pick_tag();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return 16'($urandom);
    return 16'($urandom_range(1, 14));
  endfunction

  function automatic logic [31:0] pick_dest();
    logic [31:0] m;
    m = net_mask;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return host_pool[$urandom_range(0, POOL_SIZE - 1)];
      4:          return (net_base & m) | ~m;
      5:          return vspc_pkg::ALL_ONES;
      6:          return extra_bcast;
      7:          return (net_base & m) | ($urandom & ~m);
      default:    return $urandom;
    endcase
  endfunction

  // Mostly well-formed headers, the rest malformed or random
  function automatic vspc_pkg::in_item_t random_route();
    int ihl;
    int pick;
    pick = $urandom_range(0, 9);
    ihl = $urandom_range(5, 15);
    if (pick == 0) return route_item(VER4, ihl, $urandom_range(0, 65535), pick_dest());
    if (pick < 8) return route_item(VER4, ihl, $urandom_range(ihl * 4, ihl * 4 + 64),
                                    pick_dest());
    if (pick == 8) return route_item($urandom_range(0, 15), $urandom_range(0, 15),
                                     $urandom_range(0, 80), pick_dest());
    return noise_item();
  endfunction

  task automatic queue_random(input int n, input int w_add, input int w_remove,
                              input int w_clear);
    int r;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < w_add)
        enqueue(add_item(host_pool[$urandom_range(0, POOL_SIZE - 1)], pick_tag()));
      else if (r < w_add + w_remove)
        enqueue(remove_item(pick_tag()));
      else if (r < w_add + w_remove + w_clear)
        enqueue(clear_item());
      else
        enqueue(random_route());
    end
  endtask

  initial begin
    int          ph;
    int          plen;
    logic [31:0] b;
    logic [31:0] m;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: header checks, subnet checks, host entry rules, counter clear
    set_subnet(32'h0A08_0000, 32'hFFFF_FF00, vspc_pkg::EXTRA_BCAST_RESET);
    @(posedge clk);
    enqueue(route_item(VER4, 5, 19, 32'h0A08_0001));          // too short
    enqueue(route_item(6, 5, 40, 32'h0A08_0001));             // not IPv4
    enqueue(route_item(VER4, 4, 40, 32'h0A08_0001));          // header too small
    enqueue(route_item(VER4, 15, 59, 32'h0A08_0001));         // header past end
    enqueue(route_item(VER4, 15, 60, 32'h0A08_0001));         // tunnel
    enqueue(route_item(VER4, 5, 20, 32'h0A09_0001));          // outside subnet
    enqueue(route_item(VER4, 5, 20, vspc_pkg::ALL_ONES));
    enqueue(route_item(VER4, 5, 20, 32'h0A08_00FF));          // subnet broadcast
    enqueue(add_item(32'h0A08_0005, 16'd7));
    enqueue(route_item(VER4, 5, 100, 32'h0A08_0005));
    enqueue(add_item(32'h0A08_0005, 16'hFFFF));               // overwrite id
    enqueue(route_item(VER4, 5, 100, 32'h0A08_0005));
    enqueue(add_item(32'h0A08_0006, 16'd0));                  // zero id entry
    enqueue(route_item(VER4, 5, 100, 32'h0A08_0006));
    enqueue(add_item(vspc_pkg::ALL_ONES, 16'd9));
    enqueue(route_item(VER4, 5, 100, vspc_pkg::ALL_ONES));
    enqueue(remove_item(16'd0));
    enqueue(remove_item(16'h1234));                           // no such id
    enqueue(remove_item(16'hFFFF));
    enqueue(route_item(VER4, 5, 65535, 32'h0A08_0005));
    enqueue(clear_item());
    enqueue(route_item(15, 0, 0, 32'h0000_0000));
    wait_idle();

    // Extra broadcast outside the subnet passes the subnet check only
    write_reg(vspc_pkg::CFG_EXTRA_BCAST, 32'h0102_0304);
    @(posedge clk);
    enqueue(route_item(VER4, 5, 20, 32'h0102_0304));
    enqueue(add_item(32'h0102_0304, 16'd3));
    enqueue(route_item(VER4, 5, 20, 32'h0102_0304));

    // Random phases, each under its own subnet setting
    for (ph = 1; ph <= 8; ph++) begin
      wait_idle();
      b = $urandom;
      case (ph)
        1: set_subnet('0, '0, '0);
        2: set_subnet(vspc_pkg::ALL_ONES, vspc_pkg::ALL_ONES, vspc_pkg::ALL_ONES);
        3: set_subnet(32'h0A08_0000, 32'hFFFF_FF00, vspc_pkg::EXTRA_BCAST_RESET);
        4: set_subnet(b, 32'hFFFF_FFF0, $urandom);
        5: begin
          plen = $urandom_range(1, 31);
          m = 32'hFFFF_FFFF << (32 - plen);
          set_subnet(b, m, (b & m) | ~m);
        end
        6: begin
          plen = $urandom_range(16, 30);
          m = 32'hFFFF_FFFF << (32 - plen);
          set_subnet(b, m, (b & m) | ($urandom & ~m));
        end
        7: set_subnet(32'h0A08_0000, 32'hFFFF_FF00, '0);
        default: set_subnet(b, $urandom, $urandom);
      endcase
      tx_eager = (ph == 2 || ph == 6);
      rx_eager = (ph == 2 || ph == 5);
      @(posedge clk);
      // phase 3 fills the host table, phase 7 empties it again
      if (ph == 3) queue_random(PHASE_ITEMS, 55, 0, 1);
      else if (ph == 7) queue_random(PHASE_ITEMS, 20, 25, 3);
      else queue_random(PHASE_ITEMS, 15, 8, 2);
    end

    wait_idle();
    repeat (TABLE_DEPTH + 8) @(posedge clk);
    if (n_errors == 0 && verdict_queue.size() == 0) begin
      $display("virtual_subnet_packet_classifier_unit: match");
    end else begin
      $display("virtual_subnet_packet_classifier_unit: mismatch");
    end
    $finish;
  end

endmodule
